/* rtl/wcpd_pkg.sv */
// package: constants, shared types and bit-level helper functions of the packet decoder
package wcpd_pkg;

  localparam int unsigned PktLen    = 24;
  localparam int unsigned BodyFirst = 8;
  localparam int unsigned WalkLen   = 12;
  localparam int unsigned PosW      = $clog2(PktLen + 1);
  localparam int unsigned StoreDepth = PktLen - BodyFirst;
  localparam int unsigned StoreAw   = $clog2(StoreDepth);
  localparam int unsigned WalkCntW  = $clog2(WalkLen + 1);

  localparam logic [6:0]  LFSR_SEED = 7'h6F;
  localparam logic [6:0]  LFSR_TAPS = 7'h11;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  // raw command bytes
  localparam logic [7:0] CMD_ON         = 8'h10;
  localparam logic [7:0] CMD_OFF        = 8'h11;
  localparam logic [7:0] CMD_NIGHT      = 8'h12;
  localparam logic [7:0] CMD_BRIGHTNESS = 8'h21;
  localparam logic [7:0] CMD_PAIR       = 8'h28;

  // decoded command kinds
  localparam logic [2:0] KIND_UNKNOWN    = 3'd0;
  localparam logic [2:0] KIND_ON         = 3'd1;
  localparam logic [2:0] KIND_OFF        = 3'd2;
  localparam logic [2:0] KIND_NIGHT      = 3'd3;
  localparam logic [2:0] KIND_BRIGHTNESS = 3'd4;
  localparam logic [2:0] KIND_PAIR       = 3'd5;

  typedef struct packed {
    logic               byte_en;    // take the item as packet byte pos
    logic               start;      // restart generator, prefix flag and chained crc
    logic [PosW-1:0]    pos;        // effective byte position of the item
    logic               walk_init;  // load the walk crc with ~seed
    logic               walk_step;  // fold the registered store byte into the walk crc
    logic [StoreAw-1:0] rd_addr;
    logic               load_out;   // move the decoded fields into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [7:0] mask;
    logic [6:0] lfsr;
  } whiten_t;

  function automatic whiten_t whiten(input logic [6:0] lfsr);
    logic [7:0] r;
    whiten_t    res;
    r = {1'b0, lfsr};
    res.mask = '0;
    for (int j = 0; j < 8; j++) begin
      r = {r[6:0], 1'b0};
      if (r[7]) begin
        r = r ^ {1'b0, LFSR_TAPS};
        res.mask[j] = 1'b1;
      end
      r[7] = 1'b0;
    end
    res.lfsr = r[6:0];
    return res;
  endfunction

  function automatic logic [7:0] bit_rev(input logic [7:0] v);
    logic [7:0] r;
    for (int j = 0; j < 8; j++) begin
      r[j] = v[7-j];
    end
    return r;
  endfunction

  // crc-16, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = 8'hAA;
      3'd1:    v = 8'h98;
      3'd2:    v = 8'h43;
      3'd3:    v = 8'hAF;
      3'd4:    v = 8'h0B;
      default: v = 8'h46;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] cmd_kind(input logic [7:0] cmd);
    logic [2:0] k;
    unique case (cmd)
      CMD_ON:         k = KIND_ON;
      CMD_OFF:        k = KIND_OFF;
      CMD_NIGHT:      k = KIND_NIGHT;
      CMD_BRIGHTNESS: k = KIND_BRIGHTNESS;
      CMD_PAIR:       k = KIND_PAIR;
      default:        k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

/* rtl/wcpd_in_if.sv */
// interface: input channel carrying one encoded packet byte per item
interface wcpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] encoded_byte;
  logic       packet_start;

  modport source (output valid, output encoded_byte, output packet_start, input ready);
  modport sink   (input valid, input encoded_byte, input packet_start, output ready);
endinterface

/* rtl/wcpd_out_if.sv */
// interface: output channel carrying one decoded packet per item
interface wcpd_out_if;
  logic        valid;
  logic        ready;
  logic        prefix_ok;
  logic [7:0]  command_code;
  logic [2:0]  command_kind;
  logic [15:0] group_word;
  logic [23:0] arg_bytes;
  logic [7:0]  xmit_count;
  logic [15:0] seed_value;
  logic        r2_ok;
  logic [23:0] full_id;
  logic        crc_ok;
  logic        crc2_ok;

  modport source (
    output valid, output prefix_ok, output command_code, output command_kind,
    output group_word, output arg_bytes, output xmit_count, output seed_value,
    output r2_ok, output full_id, output crc_ok, output crc2_ok,
    input ready
  );
  modport sink (
    input valid, input prefix_ok, input command_code, input command_kind,
    input group_word, input arg_bytes, input xmit_count, input seed_value,
    input r2_ok, input full_id, input crc_ok, input crc2_ok,
    output ready
  );
endinterface

/* rtl/wcpd_ctrl.sv */
// controller: byte position, crc walk sequencing and output load
module wcpd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   packet_start_i,
  output logic                   in_ready_o,
  input  wcpd_pkg::dp_status_t   status_i,
  output wcpd_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_WALK = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  state_e                            state_q, state_d;
  logic [wcpd_pkg::PosW-1:0]         pos_q, pos_d, pos_eff;
  logic [wcpd_pkg::WalkCntW-1:0]     cnt_q, cnt_d;
  logic                              in_acc;

  assign in_ready_o = (state_q == ST_RUN);
  assign in_acc     = in_valid_i && in_ready_o;
  assign pos_eff    = packet_start_i ? '0 : pos_q;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.pos     = pos_eff;
    cmd_o.start   = packet_start_i;
    cmd_o.rd_addr = cnt_q[wcpd_pkg::StoreAw-1:0];
    unique case (state_q)
      ST_RUN: begin
        // past the last byte an item without a start mark is dropped
        if (in_acc && (pos_eff < wcpd_pkg::PosW'(wcpd_pkg::PktLen))) begin
          cmd_o.byte_en = 1'b1;
          pos_d = pos_eff + wcpd_pkg::PosW'(1);
          if (pos_eff == wcpd_pkg::PosW'(wcpd_pkg::PktLen - 1)) begin
            cmd_o.walk_init = 1'b1;
            cnt_d   = '0;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // count 0 only issues the first read
        cmd_o.walk_step = (cnt_q != '0);
        cnt_d = cnt_q + wcpd_pkg::WalkCntW'(1);
        if (cnt_q == wcpd_pkg::WalkCntW'(wcpd_pkg::WalkLen)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* rtl/wcpd_datapath.sv */
// datapath: de-whitening, prefix check, crcs, byte store and output register
module wcpd_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           encoded_byte_i,
  input  wcpd_pkg::ctrl_cmd_t  cmd_i,
  output wcpd_pkg::dp_status_t status_o,
  wcpd_out_if.source           out_o
);

  logic [6:0]  lfsr_q, lfsr_d, lfsr_eff;
  logic        prefix_q, prefix_d, prefix_eff;
  logic [15:0] chain_q, chain_d, chain_eff;
  logic [15:0] walk_q, walk_d;
  logic [7:0]  plain;
  logic        in_chain;
  logic [wcpd_pkg::PosW-1:0] body_off;
  wcpd_pkg::whiten_t wh;

  logic [7:0] store_mem [wcpd_pkg::StoreDepth];
  logic [7:0] rdata_q;

  // captured plaintext bytes 8..14 and 16..23
  logic [7:0] b8_q, b9_q, b10_q, b11_q, b12_q, b13_q, b14_q, b16_q;
  logic [7:0] b17_q, b18_q, b19_q, b20_q, b21_q, b22_q, b23_q;

  logic out_valid_q;

  assign lfsr_eff   = cmd_i.start ? wcpd_pkg::LFSR_SEED : lfsr_q;
  assign prefix_eff = cmd_i.start ? 1'b1 : prefix_q;
  assign chain_eff  = cmd_i.start ? wcpd_pkg::CRC_INIT : chain_q;
  assign wh         = wcpd_pkg::whiten(lfsr_eff);
  assign plain      = wcpd_pkg::bit_rev(encoded_byte_i ^ wh.mask);
  assign body_off   = cmd_i.pos - wcpd_pkg::PosW'(wcpd_pkg::BodyFirst);
  // chained crc covers bytes 1-5 and 8-21
  assign in_chain   = ((cmd_i.pos >= 5'd1) && (cmd_i.pos <= 5'd5)) ||
                      ((cmd_i.pos >= 5'd8) && (cmd_i.pos <= 5'd21));

  always_comb begin
    lfsr_d   = lfsr_q;
    prefix_d = prefix_q;
    chain_d  = chain_q;
    if (cmd_i.byte_en) begin
      lfsr_d   = wh.lfsr;
      prefix_d = prefix_eff;
      chain_d  = chain_eff;
      if (cmd_i.pos < wcpd_pkg::PosW'(wcpd_pkg::BodyFirst)) begin
        prefix_d = prefix_eff && (plain == wcpd_pkg::prefix_byte(cmd_i.pos[2:0]));
      end
      if (in_chain) begin
        chain_d = wcpd_pkg::crc_byte(chain_eff, plain);
      end
    end
  end

  always_comb begin
    walk_d = walk_q;
    if (cmd_i.walk_init) begin
      walk_d = ~{b18_q, b19_q};
    end else if (cmd_i.walk_step) begin
      walk_d = wcpd_pkg::crc_byte(walk_q, rdata_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q   <= wcpd_pkg::LFSR_SEED;
      prefix_q <= 1'b1;
      chain_q  <= wcpd_pkg::CRC_INIT;
    end else begin
      lfsr_q   <= lfsr_d;
      prefix_q <= prefix_d;
      chain_q  <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q <= walk_d;
  end

  // byte store for the seeded crc walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_en && (cmd_i.pos >= wcpd_pkg::PosW'(wcpd_pkg::BodyFirst))) begin
      store_mem[body_off[wcpd_pkg::StoreAw-1:0]] <= plain;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= store_mem[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_en) begin
      unique case (cmd_i.pos)
        5'd8:    b8_q  <= plain;
        5'd9:    b9_q  <= plain;
        5'd10:   b10_q <= plain;
        5'd11:   b11_q <= plain;
        5'd12:   b12_q <= plain;
        5'd13:   b13_q <= plain;
        5'd14:   b14_q <= plain;
        5'd16:   b16_q <= plain;
        5'd17:   b17_q <= plain;
        5'd18:   b18_q <= plain;
        5'd19:   b19_q <= plain;
        5'd20:   b20_q <= plain;
        5'd21:   b21_q <= plain;
        5'd22:   b22_q <= plain;
        5'd23:   b23_q <= plain;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_o.prefix_ok    <= prefix_q;
      out_o.command_code <= b8_q;
      out_o.command_kind <= wcpd_pkg::cmd_kind(b8_q);
      out_o.group_word   <= {b10_q, b9_q};
      out_o.arg_bytes    <= {b13_q, b12_q, b11_q};
      out_o.xmit_count   <= b14_q;
      out_o.seed_value   <= {b18_q, b19_q};
      out_o.r2_ok        <= (b17_q == b19_q);
      out_o.full_id      <= {b16_q ^ b19_q, b10_q, b9_q};
      out_o.crc_ok       <= (walk_q == {b20_q, b21_q});
      out_o.crc2_ok      <= (chain_q == {b22_q, b23_q});
    end
  end

  assign out_o.valid       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_o.ready;

endmodule

/* rtl/whitened_crc_packet_decoder_unit.sv */
// top level: whitened crc packet decoder, controller plus datapath
// Usage:
//   in_i carries one encoded packet byte per item with a start mark on byte 0;
//   the start mark restarts the decode at any point. Without one, bytes after
//   byte 23 are taken and dropped.
//   out_o carries one decoded packet per item: fields, prefix and crc flags.
// Byte flow:
//   bytes 0-22 are taken back to back. Byte 23 starts the seeded crc walk over
//   the twelve stored bytes 8-19, one store read per cycle with a registered
//   read port; in_i.ready stays low from byte 23 until the result is loaded
//   into the output register.
// Stall:
//   the result sits in an output register, so the next packet is taken while
//   it waits; a second result waits in the controller, with in_i.ready low,
//   until out_o.ready frees the register.
// Reset:
//   rst_ni clears position, whitening generator, prefix flag, chained crc and
//   the output valid; a byte without a start mark after reset is byte 0.
module whitened_crc_packet_decoder_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  wcpd_in_if.sink   in_i,
  wcpd_out_if.source out_o
);

  wcpd_pkg::ctrl_cmd_t  cmd;
  wcpd_pkg::dp_status_t status;

  wcpd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .packet_start_i (in_i.packet_start),
    .in_ready_o     (in_i.ready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  wcpd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .encoded_byte_i (in_i.encoded_byte),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_o          (out_o)
  );

endmodule
